FILE: src/zmpe_pkg.sv
package zmpe_pkg;

	localparam int QF = 24;
	localparam logic signed [31:0] Q_ONE = 32'sd16777216;

	typedef struct packed {
		logic [3:0] n;
		logic [3:0] am;
		logic       neg;
		logic [2:0] h;
	} mode_t;

	typedef mode_t [63:0] mode_tab_t;
	typedef logic [10:0][10:0][7:0] binom_tab_t;

	function automatic mode_tab_t build_mode_tab();
		mode_tab_t tab;
		int n;
		int r;
		int m;
		int am;
		for (int j = 0; j < 64; j++) begin
			n = 0;
			r = j;
			while (r > n) begin
				n++;
				r -= n;
			end
			m = 2 * r - n;
			am = (m < 0) ? -m : m;
			tab[j].n = 4'(n);
			tab[j].am = 4'(am);
			tab[j].neg = (m < 0);
			tab[j].h = 3'((n - am) >> 1);
		end
		return tab;
	endfunction

	function automatic binom_tab_t build_binom();
		binom_tab_t tab;
		tab = '0;
		for (int a = 0; a <= 10; a++) begin
			tab[a][0] = 8'd1;
			for (int b = 1; b <= a; b++) begin
				tab[a][b] = tab[a-1][b-1] + ((b <= a - 1) ? tab[a-1][b] : 8'd0);
			end
		end
		return tab;
	endfunction

	localparam mode_tab_t MODE_TAB = build_mode_tab();
	localparam binom_tab_t BINOM = build_binom();

endpackage

FILE: src/zernike_mode_pixel_evaluator.sv
// A pixel outside the grid, a mode out of range or a cropped pixel goes from the
// preparation state straight to the output state and skips the arithmetic.
// One item at a time: the next item is taken once the current result is in the
// output register; one shared signed multiplier and a 25-step divider do the arithmetic.
// Reset (arst_n low, asynchronous) sets grid_size to 256 and empties the output.
module zernike_mode_pixel_evaluator #(
	parameter int MAX_GRID  = 1024,
	parameter int MAX_MODES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [10:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // pixel_row[9:0], pixel_col[19:10], mode_index[25:20]
	input  logic        s_axis_tuser,  // apply_crop
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // mode_value[31:0]
	output logic        m_axis_tuser   // inside_circle
);
	import zmpe_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_PREP, S_DIV, S_XY, S_ANG, S_SQ, S_TERM, S_RND, S_SAT, S_OUT
	} state_t;

	state_t state_q;
	logic [10:0] gs_q;
	logic [9:0]  row_q, col_q;
	logic [5:0]  j_q;
	logic        crop_q;
	logic [9:0]  c_q;
	logic        sx_q, sy_q;
	logic [9:0]  rx_q, ry_q;
	logic [24:0] nx_q, ny_q, qx_q, qy_q;
	logic [4:0]  div_cnt_q;
	logic [3:0]  n_q, am_q, ang_cnt_q;
	logic        neg_q;
	logic [2:0]  h_q, k_q, ph_q;
	logic signed [25:0] x_q, y_q;
	logic signed [31:0] re_q, im_q, pw_q, s_q, ang_q;
	logic signed [44:0] tmp_q, nr_q;
	logic signed [36:0] tq_q;
	logic [11:0] coef_q;
	logic signed [51:0] acc_q;
	logic [51:0] rmag_q;
	logic        sgn_q;
	logic [31:0] res_val_q;
	logic        res_in_q;
	logic        m_valid_q;
	logic [31:0] m_data_q;
	logic        m_user_q;
	logic signed [68:0] prod_s1;

	logic [10:0] size_w;
	logic [9:0]  c_w, mx_w, my_w;
	logic signed [11:0] dx_w, dy_w, ndx_w, ndy_w;
	logic [20:0] r2_w;
	logic [19:0] c2_w;
	logic        inside_w, out_grid_w, mode_ok_w;
	mode_t       mode_w;
	logic [10:0] tx_w, ty_w;
	logic        gex_w, gey_w;
	logic [9:0]  rxn_w, ryn_w;
	logic signed [36:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [68:0] prod_w;
	logic [68:0] pmag_w, rsum_w;
	logic [44:0] rmag_w;
	logic signed [44:0] rnd_w, add_w, sub_w;
	logic [3:0]  a1_w, a2_w, b2_w, kx_w;
	logic [15:0] coef_w;
	logic signed [51:0] nacc_w;
	logic [43:0] v_w;

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = m_data_q;
	assign m_axis_tuser = m_user_q;

	always_comb begin
		if (gs_q < 11'd2) begin
			size_w = 11'd2;
		end else if (int'(gs_q) > MAX_GRID) begin
			size_w = 11'(MAX_GRID);
		end else begin
			size_w = gs_q;
		end
		c_w = size_w[10:1];
		out_grid_w = ({1'b0, row_q} >= size_w) || ({1'b0, col_q} >= size_w);
		dx_w = $signed({2'b0, col_q}) - $signed({2'b0, c_w});
		dy_w = $signed({2'b0, c_w}) - $signed({2'b0, row_q});
		ndx_w = -dx_w;
		ndy_w = -dy_w;
		mx_w = dx_w[11] ? ndx_w[9:0] : dx_w[9:0];
		my_w = dy_w[11] ? ndy_w[9:0] : dy_w[9:0];
		r2_w = {11'd0, mx_w} * {11'd0, mx_w} + {11'd0, my_w} * {11'd0, my_w};
		c2_w = c_w * c_w;
		inside_w = r2_w < {1'b0, c2_w};
		mode_w = MODE_TAB[j_q];
		mode_ok_w = int'(j_q) < MAX_MODES;
	end

	always_comb begin
		tx_w = {1'b0, rx_q} << 1 | {10'd0, nx_q[24]};
		ty_w = {1'b0, ry_q} << 1 | {10'd0, ny_q[24]};
		gex_w = tx_w >= {1'b0, c_q};
		gey_w = ty_w >= {1'b0, c_q};
		rxn_w = gex_w ? 10'(tx_w - {1'b0, c_q}) : tx_w[9:0];
		ryn_w = gey_w ? 10'(ty_w - {1'b0, c_q}) : ty_w[9:0];
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_ANG: begin
				case (ph_q)
					3'd0: begin mul_a = 37'(re_q); mul_b = 32'(x_q); end
					3'd1: begin mul_a = 37'(im_q); mul_b = 32'(y_q); end
					3'd2: begin mul_a = 37'(re_q); mul_b = 32'(y_q); end
					3'd3: begin mul_a = 37'(im_q); mul_b = 32'(x_q); end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			S_SQ: begin
				case (ph_q)
					3'd0: begin mul_a = 37'(x_q); mul_b = 32'(x_q); end
					3'd1: begin mul_a = 37'(y_q); mul_b = 32'(y_q); end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			S_TERM: begin
				case (ph_q)
					3'd0: begin mul_a = 37'(pw_q); mul_b = ang_q; end
					3'd1: begin mul_a = 37'(pw_q); mul_b = s_q; end
					3'd2: begin mul_a = tq_q; mul_b = $signed({20'd0, coef_q}); end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod_w = mul_a * mul_b;
	end

	always_comb begin
		pmag_w = prod_s1[68] ? 69'(-prod_s1) : 69'(prod_s1);
		rsum_w = pmag_w + (69'(1) << (QF - 1));
		rmag_w = rsum_w[68:24];
		rnd_w = prod_s1[68] ? -$signed(rmag_w) : $signed(rmag_w);
		add_w = tmp_q + rnd_w;
		sub_w = tmp_q - rnd_w;
		kx_w = {1'b0, k_q};
		a1_w = n_q - kx_w;
		a2_w = n_q - (kx_w << 1);
		b2_w = {1'b0, h_q} - kx_w;
		coef_w = BINOM[a1_w][kx_w] * BINOM[a2_w][b2_w];
		nacc_w = k_q[0] ? acc_q - prod_s1[51:0] : acc_q + prod_s1[51:0];
		v_w = rmag_q[51:8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			gs_q <= 11'd256;
			m_valid_q <= 1'b0;
			ph_q <= '0;
			div_cnt_q <= '0;
			ang_cnt_q <= '0;
			k_q <= '0;
		end else begin
			prod_s1 <= prod_w;
			if (cfg_wen) begin
				gs_q <= cfg_wdata;
			end
			if (state_q == S_OUT && (!m_valid_q || m_axis_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						row_q <= s_axis_tdata[9:0];
						col_q <= s_axis_tdata[19:10];
						j_q <= s_axis_tdata[25:20];
						crop_q <= s_axis_tuser;
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					res_val_q <= '0;
					res_in_q <= inside_w && !out_grid_w;
					c_q <= c_w;
					sx_q <= dx_w[11];
					sy_q <= dy_w[11];
					rx_q <= {1'b0, mx_w[9:1]};
					ry_q <= {1'b0, my_w[9:1]};
					nx_q <= {mx_w[0], 15'd0, c_w[9:1]};
					ny_q <= {my_w[0], 15'd0, c_w[9:1]};
					div_cnt_q <= 5'd24;
					n_q <= mode_w.n;
					am_q <= mode_w.am;
					neg_q <= mode_w.neg;
					h_q <= mode_w.h;
					if (out_grid_w || !mode_ok_w || (crop_q && !inside_w)) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rx_q <= rxn_w;
					ry_q <= ryn_w;
					nx_q <= nx_q << 1;
					ny_q <= ny_q << 1;
					qx_q <= {qx_q[23:0], gex_w};
					qy_q <= {qy_q[23:0], gey_w};
					div_cnt_q <= div_cnt_q - 5'd1;
					if (div_cnt_q == 5'd0) begin
						state_q <= S_XY;
					end
				end
				S_XY: begin
					x_q <= sx_q ? -$signed({1'b0, qx_q}) : $signed({1'b0, qx_q});
					y_q <= sy_q ? -$signed({1'b0, qy_q}) : $signed({1'b0, qy_q});
					re_q <= Q_ONE;
					im_q <= '0;
					ang_cnt_q <= am_q;
					ph_q <= '0;
					state_q <= (am_q != 4'd0) ? S_ANG : S_SQ;
				end
				S_ANG: begin
					ph_q <= ph_q + 3'd1;
					case (ph_q)
						3'd1: tmp_q <= rnd_w;
						3'd2: nr_q <= sub_w;
						3'd3: tmp_q <= rnd_w;
						3'd4: begin
							re_q <= nr_q[31:0];
							im_q <= add_w[31:0];
							ph_q <= '0;
							ang_cnt_q <= ang_cnt_q - 4'd1;
							if (ang_cnt_q == 4'd1) begin
								state_q <= S_SQ;
							end
						end
						default: begin
						end
					endcase
				end
				S_SQ: begin
					ph_q <= ph_q + 3'd1;
					case (ph_q)
						3'd1: tmp_q <= rnd_w;
						3'd2: begin
							s_q <= add_w[31:0];
							ang_q <= neg_q ? im_q : re_q;
							pw_q <= Q_ONE;
							k_q <= h_q;
							acc_q <= '0;
							ph_q <= '0;
							state_q <= S_TERM;
						end
						default: begin
						end
					endcase
				end
				S_TERM: begin
					ph_q <= ph_q + 3'd1;
					case (ph_q)
						3'd0: coef_q <= coef_w[11:0];
						3'd1: tq_q <= rnd_w[36:0];
						3'd2: pw_q <= rnd_w[31:0];
						3'd3: begin
							acc_q <= nacc_w;
							ph_q <= '0;
							if (k_q == 3'd0) begin
								state_q <= S_RND;
							end else begin
								k_q <= k_q - 3'd1;
							end
						end
						default: begin
						end
					endcase
				end
				S_RND: begin
					sgn_q <= acc_q[51];
					rmag_q <= (acc_q[51] ? 52'(-acc_q) : 52'(acc_q)) + 52'd128;
					state_q <= S_SAT;
				end
				S_SAT: begin
					if (!sgn_q) begin
						res_val_q <= (v_w > 44'h0007FFFFFFF) ? 32'h7FFFFFFF : v_w[31:0];
					end else begin
						res_val_q <= (v_w > 44'h00080000000) ? 32'h80000000 : 32'(-v_w[31:0]);
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!m_valid_q || m_axis_tready) begin
						m_data_q <= res_val_q;
						m_user_q <= res_in_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_accept_prep: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (state_q == S_PREP))
		else $error("accepted item did not start preparation");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rx_q < c_q) && (ry_q < c_q))
		else $error("divider remainder out of range");

	a_ang_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ANG) |-> (ang_cnt_q != 4'd0))
		else $error("angular loop ran with zero count");

	a_term_k: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TERM) |-> (k_q <= h_q))
		else $error("term index beyond radial order");

endmodule

FILE: tb/sv/zernike_mode_pixel_evaluator_test.sv
module zernike_mode_pixel_evaluator_test;

	typedef struct {
		logic [31:0] value;
		logic        in_circle;
	} zern_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wen;
	logic [10:0] cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tuser;

	zernike_mode_pixel_evaluator dut (
		.clk(clk), .arst_n(arst_n), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	localparam int WATCHDOG_LIMIT = 20000;

	zern_result_t expected_q[$];
	logic [10:0]  grid_reg;
	int           errors;
	int           sent;
	int           received;
	int           idle_cycles;
	bit           no_idle;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint fx_mul(longint a, longint b);
		longint p;
		p = a * b;
		if (p >= 0)
			return (p + (64'sd1 <<< 23)) >>> 24;
		return -((-p + (64'sd1 <<< 23)) >>> 24);
	endfunction

	function automatic longint fx_div(longint d, longint c);
		longint mag;
		longint q;
		mag = (d < 0) ? -d : d;
		q = ((mag <<< 24) + c / 2) / c;
		return (d < 0) ? -q : q;
	endfunction

	function automatic longint fact(int v);
		longint f;
		f = 1;
		for (int i = 2; i <= v; i++)
			f *= i;
		return f;
	endfunction

	function automatic zern_result_t zernike_value(logic [9:0] row_i, logic [9:0] col_i,
			logic [5:0] mode, logic crop);
		zern_result_t r;
		longint size, c, dx, dy, x, y, re, im, nr, ni, ang, s, acc, pw, coef, term, v;
		int n, rem, m, am, h;
		size = grid_reg;
		if (size < 2) size = 2;
		if (size > 1024) size = 1024;
		c = size / 2;
		r.value = '0;
		r.in_circle = 1'b0;
		if (row_i >= size || col_i >= size)
			return r;
		dx = longint'(col_i) - c;
		dy = c - longint'(row_i);
		r.in_circle = (dx * dx + dy * dy) < c * c;
		if (mode >= 64 || (crop && !r.in_circle))
			return r;
		n = 0;
		rem = mode;
		while (rem > n) begin
			n++;
			rem -= n;
		end
		m = 2 * rem - n;
		am = (m < 0) ? -m : m;
		x = fx_div(dx, c);
		y = fx_div(dy, c);
		re = 64'sd1 <<< 24;
		im = 0;
		for (int t = 0; t < am; t++) begin
			nr = fx_mul(re, x) - fx_mul(im, y);
			ni = fx_mul(re, y) + fx_mul(im, x);
			re = nr;
			im = ni;
		end
		ang = (m < 0) ? im : re;
		s = fx_mul(x, x) + fx_mul(y, y);
		h = (n - am) / 2;
		acc = 0;
		for (int k = 0; k <= h; k++) begin
			pw = 64'sd1 <<< 24;
			for (int t = 0; t < h - k; t++)
				pw = fx_mul(pw, s);
			coef = fact(n - k) / (fact(k) * fact((n + am) / 2 - k) * fact(h - k));
			term = fx_mul(pw, ang) * coef;
			if (k % 2) acc -= term;
			else acc += term;
		end
		if (acc >= 0) v = (acc + 128) >>> 8;
		else v = -((-acc + 128) >>> 8);
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		r.value = v[31:0];
		return r;
	endfunction

	task automatic send_pixel(logic [9:0] row_i, logic [9:0] col_i, logic [5:0] mode,
			logic crop);
		@(posedge clk);
		while (!no_idle && $urandom_range(99) < 9)
			@(posedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'd0, mode, col_i, row_i};
		s_axis_tuser <= crop;
		expected_q.push_back(zernike_value(row_i, col_i, mode, crop));
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sent++;
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic drain;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_grid(logic [10:0] g);
		drain();
		cfg_wen <= 1'b1;
		cfg_wdata <= g;
		grid_reg = g;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready && arst_n) begin
			received++;
			if (expected_q.size() == 0) begin
				$error("unexpected result %h", m_axis_tdata);
				errors++;
			end else begin
				if (m_axis_tdata !== expected_q[0].value) begin
					$error("mode_value expected %h actual %h", expected_q[0].value,
						m_axis_tdata);
					errors++;
				end
				if (m_axis_tuser !== expected_q[0].in_circle) begin
					$error("inside_circle expected %b actual %b", expected_q[0].in_circle,
						m_axis_tuser);
					errors++;
				end
				void'(expected_q.pop_front());
			end
		end
		m_axis_tready <= no_idle || ($urandom_range(99) >= 9);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic test_reset_grid;
		send_pixel(10'd128, 10'd128, 6'd0, 1'b0);
		send_pixel(10'd0, 10'd0, 6'd4, 1'b0);
		send_pixel(10'd128, 10'd255, 6'd1, 1'b1);
		send_pixel(10'd300, 10'd5, 6'd3, 1'b0);
	endtask

	task automatic test_directed;
		set_grid(11'd16);
		send_pixel(10'd8, 10'd8, 6'd4, 1'b0);
		send_pixel(10'd8, 10'd8, 6'd3, 1'b0);
		send_pixel(10'd0, 10'd0, 6'd63, 1'b0);
		send_pixel(10'd0, 10'd0, 6'd63, 1'b1);
		send_pixel(10'd15, 10'd15, 6'd35, 1'b0);
		send_pixel(10'd16, 10'd3, 6'd2, 1'b0);
		send_pixel(10'd3, 10'd16, 6'd2, 1'b0);
		send_pixel(10'd1023, 10'd1023, 6'd5, 1'b0);
		set_grid(11'd0);
		send_pixel(10'd0, 10'd1, 6'd12, 1'b0);
		send_pixel(10'd1, 10'd1, 6'd1, 1'b1);
		send_pixel(10'd2, 10'd0, 6'd1, 1'b0);
		set_grid(11'd2047);
		send_pixel(10'd1023, 10'd1023, 6'd62, 1'b0);
		send_pixel(10'd512, 10'd0, 6'd44, 1'b1);
		send_pixel(10'd0, 10'd512, 6'd21, 1'b0);
		set_grid(11'd1024);
		send_pixel(10'd512, 10'd1023, 6'd54, 1'b0);
		send_pixel(10'd1, 10'd1, 6'd60, 1'b0);
		set_grid(11'd3);
		send_pixel(10'd2, 10'd2, 6'd7, 1'b0);
		send_pixel(10'd1, 10'd1, 6'd0, 1'b1);
	endtask

	task automatic test_random;
		logic [10:0] g;
		logic [9:0]  lim;
		for (int phase = 0; phase < 10; phase++) begin
			case (phase % 5)
				0: g = 11'($urandom_range(2, 40));
				1: g = 11'($urandom_range(41, 1024));
				2: g = 11'($urandom_range(0, 2047));
				3: g = 11'd1024;
				default: g = 11'($urandom_range(2, 8));
			endcase
			set_grid(g);
			no_idle = (phase == 6);
			lim = (g < 2) ? 10'd1 : (g > 1024) ? 10'd1023 : 10'(g - 1);
			for (int i = 0; i < 150; i++) begin
				if ($urandom_range(9) == 0)
					send_pixel(10'($urandom), 10'($urandom), 6'($urandom), 1'($urandom));
				else
					send_pixel(10'($urandom_range(0, lim)), 10'($urandom_range(0, lim)),
						6'($urandom), 1'($urandom));
			end
			no_idle = 0;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		grid_reg = 11'd256;
		sent = 0;
		no_idle = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_grid();
		test_directed();
		test_random();
		drain();
		$display("covered %0d pixels over grid sizes 0..2047, all 64 modes, crop on and off",
			sent);
		$display("results checked: %0d", received);
		if (errors == 0 && expected_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
